// ===== rtl/cftu_pkg.sv =====
// shared types for the cumulative frequency tree unit
// item structs, controller state codes, command and status bundles
package cftu_pkg;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [15:0] increment;
	} in_item_t;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] cumulative;
		logic [31:0] norm_count;
		logic [31:0] norm_cumulative;
		logic [31:0] total;
		logic        applied;
	} out_item_t;

	localparam int unsigned LIMIT_W = 24;
	localparam int unsigned WORD_W  = 32;

	typedef enum logic [9:0] {
		ST_CLR    = 10'b00_0000_0001,
		ST_INIT   = 10'b00_0000_0010,
		ST_IDLE   = 10'b00_0000_0100,
		ST_LEAF   = 10'b00_0000_1000,
		ST_LEAFWB = 10'b00_0001_0000,
		ST_LVLRD  = 10'b00_0010_0000,
		ST_LVLWB  = 10'b00_0100_0000,
		ST_DIVGO  = 10'b00_1000_0000,
		ST_DIV    = 10'b01_0000_0000,
		ST_OUT    = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic clr;
		logic start_init;
		logic start_item;
		logic leaf_rd;
		logic leaf_wb;
		logic lvl_rd;
		logic lvl_wb;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic init_last;
		logic init_mode;
		logic at_root;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/cftu_div.sv =====
// restoring divider: low 32 bits of (v * 2^32) / tot, one bit per cycle
// uses cftu_pkg for word width
module cftu_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cftu_pkg::WORD_W-1:0] v,
	input  logic [cftu_pkg::WORD_W-1:0] tot,
	output logic                     busy,
	output logic [cftu_pkg::WORD_W-1:0] quo
);
	import cftu_pkg::*;

	localparam int unsigned CW = $clog2(WORD_W + 1);

	logic [CW-1:0]     cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W:0]   rem2;
	logic              take;

	assign rem2 = {rem_q, 1'b0};
	assign take = rem2 >= {1'b0, tot};
	assign busy = cnt_q != '0;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(WORD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient bit 32 is dropped, only the remainder carries on
			rem_q <= (v >= tot) ? v - tot : v;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= take ? WORD_W'(rem2 - {1'b0, tot}) : rem2[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], take};
		end
	end

endmodule

// ===== rtl/cftu_ctrl.sv =====
// controller state machine of the cumulative frequency tree unit
// uses cftu_pkg for state codes and command/status bundles
module cftu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cftu_pkg::sts_t sts,
	output cftu_pkg::cmd_t cmd
);
	import cftu_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.start_init = 1'b1;
				state_d = ST_LEAF;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start_item = 1'b1;
					state_d = ST_LEAF;
				end
			end
			ST_LEAF: begin
				cmd.leaf_rd = 1'b1;
				state_d = ST_LEAFWB;
			end
			ST_LEAFWB: begin
				cmd.leaf_wb = 1'b1;
				state_d = ST_LVLRD;
			end
			ST_LVLRD: begin
				if (sts.at_root) begin
					if (!sts.init_mode) state_d = ST_DIVGO;
					else if (sts.init_last) state_d = ST_IDLE;
					else state_d = ST_INIT;
				end else begin
					cmd.lvl_rd = 1'b1;
					state_d = ST_LVLWB;
				end
			end
			ST_LVLWB: begin
				cmd.lvl_wb = 1'b1;
				state_d = ST_LVLRD;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/cftu_dp.sv =====
// datapath: leaf and left-total memories, tree walk, dividers, result register
// uses cftu_pkg and instantiates cftu_div twice
module cftu_dp #(
	parameter int unsigned NUM_SYMBOLS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cftu_pkg::in_item_t            in_data,
	input  logic                          limit_wr_en,
	input  logic [cftu_pkg::LIMIT_W-1:0]  limit_wr_data,
	input  logic                          out_stall,
	output logic                          out_valid,
	output cftu_pkg::out_item_t           out_data,
	input  cftu_pkg::cmd_t                cmd,
	output cftu_pkg::sts_t                sts
);
	import cftu_pkg::*;

	localparam int unsigned SW = $clog2(NUM_SYMBOLS);
	localparam int unsigned NW = $clog2(2 * NUM_SYMBOLS - 1);
	localparam int unsigned LW = (NUM_SYMBOLS > 2) ? $clog2(NUM_SYMBOLS - 1) : 1;

	logic [WORD_W-1:0] leaf_mem [0:NUM_SYMBOLS-1];
	logic [WORD_W-1:0] left_mem [0:NUM_SYMBOLS-2];

	logic [SW-1:0]      clr_cnt_q;
	logic [SW:0]        init_cnt_q;
	logic               init_mode_q;
	logic [SW-1:0]      sym_q;
	logic               oob_q;
	logic [15:0]        inc_q;
	logic               apply_q;
	logic [WORD_W-1:0]  tot_item_q;
	logic [WORD_W-1:0]  total_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [WORD_W-1:0]  leaf_rd_q;
	logic [WORD_W-1:0]  left_rd_q;
	logic [WORD_W-1:0]  cnt_q;
	logic [WORD_W-1:0]  cum_q;
	logic [NW-1:0]      node_q;
	logic [NW-1:0]      par;
	logic [LW-1:0]      par_idx;
	logic               out_valid_q;
	out_item_t          out_q;

	logic              div_c_busy, div_m_busy;
	logic [WORD_W-1:0] div_c_quo, div_m_quo;

	assign par     = (node_q - 1'b1) >> 1;
	assign par_idx = LW'(par);

	assign sts.clr_last  = clr_cnt_q == SW'(NUM_SYMBOLS - 1);
	assign sts.init_last = init_cnt_q == (SW + 1)'(NUM_SYMBOLS);
	assign sts.init_mode = init_mode_q;
	assign sts.at_root   = node_q == '0;
	assign sts.div_done  = !div_c_busy && !div_m_busy;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			leaf_mem[clr_cnt_q] <= '0;
			if (clr_cnt_q != SW'(NUM_SYMBOLS - 1)) left_mem[LW'(clr_cnt_q)] <= '0;
		end
		if (cmd.leaf_rd) leaf_rd_q <= leaf_mem[sym_q];
		if (cmd.leaf_wb && apply_q) leaf_mem[sym_q] <= leaf_rd_q + WORD_W'(inc_q);
		if (cmd.lvl_rd) left_rd_q <= left_mem[par_idx];
		if (cmd.lvl_wb && apply_q && node_q[0]) left_mem[par_idx] <= left_rd_q + WORD_W'(inc_q);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			init_cnt_q  <= '0;
			init_mode_q <= 1'b1;
			total_q     <= '0;
			limit_q     <= {LIMIT_W{1'b1}};
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.start_init) init_cnt_q <= init_cnt_q + 1'b1;
			if (cmd.start_item) init_mode_q <= 1'b0;
			if (cmd.leaf_wb && apply_q) total_q <= total_q + WORD_W'(inc_q);
			if (limit_wr_en) limit_q <= limit_wr_data;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// item registers and walk
	always_ff @(posedge clk) begin
		if (cmd.start_init) begin
			sym_q      <= init_cnt_q[SW-1:0];
			oob_q      <= 1'b0;
			inc_q      <= 16'd1;
			apply_q    <= 1'b1;
			tot_item_q <= total_q;
		end
		if (cmd.start_item) begin
			sym_q      <= SW'(in_data.symbol);
			oob_q      <= int'(in_data.symbol) >= NUM_SYMBOLS;
			inc_q      <= in_data.increment;
			apply_q    <= (total_q < WORD_W'(limit_q)) && (int'(in_data.symbol) < NUM_SYMBOLS);
			tot_item_q <= total_q;
		end
		if (cmd.leaf_wb) begin
			cnt_q  <= oob_q ? '0 : leaf_rd_q;
			cum_q  <= oob_q ? '0 : leaf_rd_q;
			node_q <= oob_q ? '0 : NW'(2 * NUM_SYMBOLS - 2) - NW'(sym_q);
		end
		if (cmd.lvl_wb) begin
			// right children pick up the left sibling's total
			if (!node_q[0]) cum_q <= cum_q + left_rd_q;
			node_q <= par;
		end
		if (cmd.out_load) begin
			out_q.count           <= cnt_q;
			out_q.cumulative      <= cum_q;
			out_q.norm_count      <= div_c_quo;
			out_q.norm_cumulative <= (div_m_quo == '0) ? {WORD_W{1'b1}} : div_m_quo;
			out_q.total           <= tot_item_q;
			out_q.applied         <= apply_q;
		end
	end

	cftu_div u_div_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.v      (cnt_q),
		.tot    (tot_item_q),
		.busy   (div_c_busy),
		.quo    (div_c_quo)
	);

	cftu_div u_div_cum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.v      (cum_q),
		.tot    (tot_item_q),
		.busy   (div_m_busy),
		.quo    (div_m_quo)
	);

endmodule

// ===== rtl/cumulative_frequency_tree_unit.sv =====
// top level of the cumulative frequency tree unit
// depends on cftu_pkg, cftu_ctrl, cftu_dp (which holds cftu_div)
//
// adaptive symbol-frequency model for an arithmetic coder
// input channel: in_valid / in_stall / in_data beat carries symbol and increment
// output channel: out_valid / out_stall / out_data beat carries count, cumulative,
//   their values scaled to 2^32/total, the total and the applied flag
// total_limit_wr_en / total_limit_wr_data write the 24-bit limit at any idle time
// one item at a time: each item walks its leaf-to-root path through the
//   left-total memory with a read and a write state per level, then the two
//   restoring dividers run side by side
// result sits in an output register, so a new beat is taken while it waits
// a stalled output holds its beat; the block waits only if a second result
//   is ready before the first one leaves
// after reset the memories are zeroed and then every leaf is counted up by one
//   along its path; in_stall stays high until this is done, and limit writes
//   are taken meanwhile
module cumulative_frequency_tree_unit #(
	parameter int unsigned NUM_SYMBOLS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cftu_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cftu_pkg::out_item_t           out_data,
	input  logic                          total_limit_wr_en,
	input  logic [cftu_pkg::LIMIT_W-1:0]  total_limit_wr_data
);
	import cftu_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	cftu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cftu_dp #(
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (in_data),
		.limit_wr_en   (total_limit_wr_en),
		.limit_wr_data (total_limit_wr_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_data      (out_data),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== tb/sv/cumulative_frequency_tree_unit_checker.sv =====
// checker for the cumulative frequency tree unit: watches both channels,
// keeps its own copy of the frequency tree and compares every result beat
// depends on cftu_pkg
`timescale 1ns / 1ps

module cumulative_frequency_tree_unit_checker #(
	parameter int unsigned NUM_SYMBOLS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  cftu_pkg::in_item_t   in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  cftu_pkg::out_item_t  out_data,
	input  logic                 total_limit_wr_en,
	input  logic [23:0]          total_limit_wr_data,
	output int                   fail_count,
	output int                   pending_count
);
	import cftu_pkg::*;

	localparam int unsigned NODES = 2 * NUM_SYMBOLS - 1;
	localparam int unsigned INNER = NUM_SYMBOLS - 1;

	logic [31:0] tree_sum [NODES];
	logic [31:0] left_sum [INNER];
	logic [23:0] limit_q;
	out_item_t   expected_q [$];

	function automatic logic [31:0] scaled(input logic [31:0] v, input logic [31:0] tot);
		logic [63:0] num;
		begin
			if (tot == 0) return '1;
			num = {v, 32'h0};
			return 32'(num / {32'h0, tot});
		end
	endfunction

	task automatic tree_reset();
		begin
			for (int k = 0; k < NODES; k++) tree_sum[k] = (k >= INNER) ? 32'd1 : 32'd0;
			for (int k = INNER - 1; k >= 0; k--) begin
				left_sum[k] = tree_sum[2*k+1];
				tree_sum[k] = tree_sum[2*k+1] + tree_sum[2*k+2];
			end
			limit_q = 24'hFFFFFF;
		end
	endtask

	// query the symbol, then, if the total is under the limit, add its increment along the path to the root
	function automatic out_item_t tree_step(input in_item_t it);
		out_item_t r;
		int unsigned node, par;
		logic [31:0] tot, cum;
		begin
			tot = tree_sum[0];
			r = '0;
			r.total = tot;
			if (it.symbol >= NUM_SYMBOLS) begin
				r.norm_cumulative = '1;
				return r;
			end
			node = 2 * NUM_SYMBOLS - 2 - it.symbol;
			r.count = tree_sum[node];
			cum = r.count;
			while (node > 0) begin
				par = (node - 1) / 2;
				if (node[0] == 1'b0) cum += left_sum[par];
				node = par;
			end
			r.cumulative = cum;
			r.norm_count = scaled(r.count, tot);
			r.norm_cumulative = scaled(cum, tot);
			if (r.norm_cumulative == 0) r.norm_cumulative = '1;
			r.applied = tot < {8'h0, limit_q};
			if (r.applied) begin
				node = 2 * NUM_SYMBOLS - 2 - it.symbol;
				tree_sum[node] += it.increment;
				while (node > 0) begin
					par = (node - 1) / 2;
					if (node[0] == 1'b1) left_sum[par] += it.increment;
					node = par;
					tree_sum[node] += it.increment;
				end
			end
			return r;
		end
	endfunction

	initial begin
		fail_count = 0;
		tree_reset();
	end

	assign pending_count = expected_q.size();

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (total_limit_wr_en) limit_q <= total_limit_wr_data;
			if (in_valid && !in_stall) expected_q.push_back(tree_step(in_data));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result beat %p", $realtime, out_data);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (want !== out_data) begin
						$display("%0t: expected %p actual %p", $realtime, want, out_data);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/cumulative_frequency_tree_unit_tb.sv =====
// testbench top for the cumulative frequency tree unit: clock, reset,
// directed and random beats, limit writes, verdict
// depends on cftu_pkg, the block and cumulative_frequency_tree_unit_checker
`timescale 1ns / 1ps

module cumulative_frequency_tree_unit_tb;
	import cftu_pkg::*;

	localparam int unsigned NUM_SYMBOLS = 256;
	localparam int WATCHDOG_LIMIT = 200000;   // covers the post-reset tree build
	localparam int TAIL_CYCLES = 120;

	logic       clk, arst_n;
	logic       in_valid, in_stall, out_valid, out_stall;
	in_item_t   in_data;
	out_item_t  out_data;
	logic       limit_wr_en;
	logic [23:0] limit_wr_data;
	int         fail_count, pending_count;
	int         idle_cycles;
	bit         quiet_tail;     // no idling near the end of the run
	bit         hold_receiver;  // long receiver hold-off request

	cumulative_frequency_tree_unit #(.NUM_SYMBOLS(NUM_SYMBOLS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.total_limit_wr_en(limit_wr_en), .total_limit_wr_data(limit_wr_data)
	);

	cumulative_frequency_tree_unit_checker #(.NUM_SYMBOLS(NUM_SYMBOLS)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.total_limit_wr_en(limit_wr_en), .total_limit_wr_data(limit_wr_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_receiver) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				hold_receiver = 1'b0;
				@(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// one input beat, with a random gap first unless in the tail
	task automatic send_beat(input logic [7:0] sym, input logic [15:0] inc);
		begin
			if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data <= '{symbol: sym, increment: inc};
			do @(posedge clk); while (in_stall);
		end
	endtask

	// wait until every expected beat has come, then let the block settle
	task automatic drain();
		begin
			in_valid <= 1'b0;
			while (pending_count != 0) @(posedge clk);
			repeat (TAIL_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_limit(input logic [23:0] v);
		begin
			limit_wr_en <= 1'b1;
			limit_wr_data <= v;
			@(posedge clk);
			limit_wr_en <= 1'b0;
		end
	endtask

	initial begin
		logic [7:0]  sym;
		logic [15:0] inc;
		idle_cycles = 0;
		quiet_tail = 1'b0;
		hold_receiver = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		limit_wr_en = 1'b0;
		limit_wr_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes at the reset limit
		send_beat(8'd0, 16'd0);
		send_beat(8'd255, 16'd0);
		send_beat(8'd0, 16'hFFFF);
		send_beat(8'd255, 16'hFFFF);
		send_beat(8'd128, 16'h5555);
		send_beat(8'd127, 16'hAAAA);
		send_beat(8'd1, 16'd1);
		send_beat(8'd0, 16'd0);
		send_beat(8'd255, 16'd0);
		drain();

		// zero limit blocks every update
		write_limit(24'd0);
		send_beat(8'd10, 16'hFFFF);
		send_beat(8'd10, 16'd0);
		drain();

		// lowest nonzero limit, then a limit above the current total
		write_limit(24'd1);
		send_beat(8'd200, 16'd7);
		drain();
		write_limit(24'h2AAAAA);
		for (int i = 0; i < 8; i++) send_beat(8'(i * 37), 16'hFFFF);
		drain();

		// back-pressure: receiver holds off while beats keep coming
		write_limit(24'hFFFFFF);
		hold_receiver = 1'b1;
		for (int i = 0; i < 6; i++) send_beat(8'($urandom), 16'($urandom));
		drain();

		// random: small increments mostly, large ones sometimes
		for (int i = 0; i < 500; i++) begin
			if (i == 150) begin
				drain();
				write_limit(24'($urandom_range(256, 24'h0FFFFF)));
			end
			if (i == 300) begin
				drain();
				write_limit(24'hFFFFFF);
			end
			if (i == 420) quiet_tail = 1'b1;
			sym = 8'($urandom);
			case ($urandom_range(0, 3))
				0: inc = 16'($urandom);
				1: inc = 16'd0;
				default: inc = 16'($urandom_range(1, 64));
			endcase
			send_beat(sym, inc);
		end
		drain();

		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/cftu_pkg.sv
rtl/cftu_div.sv
rtl/cftu_ctrl.sv
rtl/cftu_dp.sv
rtl/cumulative_frequency_tree_unit.sv
tb/sv/cumulative_frequency_tree_unit_checker.sv
tb/sv/cumulative_frequency_tree_unit_tb.sv
